// ----- hw/rtl/sca_pkg.sv -----
// ----------------------------------------------------------------------------
// sca_pkg: shared types and constants of the sigma-clipped average unit
// Configuration layout, register indexes, controller states and the command
// and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

  // Field widths fixed by the interface
  localparam int RAW_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int TEMP_W     = 13;
  localparam int KEPT_W     = 7;
  localparam int SQ_W       = 64;

  // Calibration gain is Q2.14
  localparam int GAIN_SHIFT = 14;

  // Saturation bounds of the temperature word
  localparam int TEMP_MIN = -4096;
  localparam int TEMP_MAX = 4095;

  // Status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ABORT = 1'b1;

  // Register reset values
  localparam logic [11:0]        LOW_LIMIT_RST   = 12'd100;
  localparam logic [11:0]        HIGH_LIMIT_RST  = 12'd4000;
  localparam logic [17:0]        INTERCEPT_RST   = 18'd111930;
  localparam logic [15:0]        SLOPE_RST       = 16'd30687;
  localparam logic [15:0]        GAIN_RST        = 16'd16712;
  localparam logic signed [15:0] OFFSET_RST      = -16'sd192;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT        = 3'd0,
    CFG_HIGH_LIMIT       = 3'd1,
    CFG_SENSOR_INTERCEPT = 3'd2,
    CFG_SENSOR_SLOPE     = 3'd3,
    CFG_CALIB_GAIN       = 3'd4,
    CFG_CALIB_OFFSET     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0]        low_limit;
    logic [11:0]        high_limit;
    logic [17:0]        sensor_intercept;
    logic [15:0]        sensor_slope;
    logic [15:0]        calib_gain;
    logic signed [15:0] calib_offset;
  } cfg_t;

  typedef enum logic {
    DIV_MEAN = 1'b0,
    DIV_KEPT = 1'b1
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_MEAN_DIV,
    ST_MEAN_WAIT,
    ST_CAL_MUL,
    ST_CAL_ADD,
    ST_SQ_RD,
    ST_SQ_MUL,
    ST_SQ_WAIT,
    ST_SQ_ACC,
    ST_LIMIT,
    ST_KP_RD,
    ST_KP_MUL,
    ST_KP_WAIT,
    ST_KP_ACC,
    ST_KEEP_DIV,
    ST_KEEP_WAIT,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic     capture;
    logic     commit;
    logic     abort;
    logic     div_start;
    div_sel_t div_sel;
    logic     mean_mul;
    logic     mean_load;
    logic     cal_mul;
    logic     cal_add;
    logic     mul_start;
    logic     acc_sq;
    logic     acc_keep;
    logic     limit_calc;
    logic     out_fire;
  } dp_cmd_t;

  typedef struct packed {
    logic in_bad;
    logic batch_last;
    logic div_done;
    logic mul_done;
    logic elem_last;
    logic kept_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sca_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sca_cfg_regs: configuration register file
// Holds the six window and calibration registers; writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sca_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sca_pkg::cfg_t                         cfg
);

  sca_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the index and load the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_limit        <= sca_pkg::LOW_LIMIT_RST;
      cfg_r.high_limit       <= sca_pkg::HIGH_LIMIT_RST;
      cfg_r.sensor_intercept <= sca_pkg::INTERCEPT_RST;
      cfg_r.sensor_slope     <= sca_pkg::SLOPE_RST;
      cfg_r.calib_gain       <= sca_pkg::GAIN_RST;
      cfg_r.calib_offset     <= sca_pkg::OFFSET_RST;
    end else if (cfg_valid) begin
      unique case (sca_pkg::cfg_idx_t'(cfg_index))
        sca_pkg::CFG_LOW_LIMIT:        cfg_r.low_limit        <= cfg_data[11:0];
        sca_pkg::CFG_HIGH_LIMIT:       cfg_r.high_limit       <= cfg_data[11:0];
        sca_pkg::CFG_SENSOR_INTERCEPT: cfg_r.sensor_intercept <= cfg_data[17:0];
        sca_pkg::CFG_SENSOR_SLOPE:     cfg_r.sensor_slope     <= cfg_data[15:0];
        sca_pkg::CFG_CALIB_GAIN:       cfg_r.calib_gain       <= cfg_data[15:0];
        sca_pkg::CFG_CALIB_OFFSET:     cfg_r.calib_offset     <= $signed(cfg_data[15:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sca_ctrl.sv -----
// ----------------------------------------------------------------------------
// sca_ctrl: batch sequencer
// Steps through sample capture, mean division, calibration, the squared
// deviation pass, the outlier pass, the kept-mean division and result issue.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire sca_pkg::dp_sts_t sts,
  output sca_pkg::dp_cmd_t      cmd
);

  sca_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sca_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = sca_pkg::DIV_MEAN;
    busy        = 1'b1;
    unique case (state_r)
      sca_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = sca_pkg::ST_SAMPLE;
        end
      end
      sca_pkg::ST_SAMPLE: begin
        if (sts.in_bad) begin
          cmd.abort = 1'b1;
          state_nxt = sca_pkg::ST_IDLE;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = sts.batch_last ? sca_pkg::ST_MEAN_DIV : sca_pkg::ST_IDLE;
        end
      end
      sca_pkg::ST_MEAN_DIV: begin
        cmd.mean_mul = 1'b1;
        cmd.div_sel  = sca_pkg::DIV_MEAN;
        state_nxt    = sca_pkg::ST_MEAN_WAIT;
      end
      sca_pkg::ST_MEAN_WAIT: begin
        cmd.mean_load = 1'b1;
        state_nxt     = sca_pkg::ST_CAL_MUL;
      end
      sca_pkg::ST_CAL_MUL: begin
        cmd.cal_mul = 1'b1;
        state_nxt   = sca_pkg::ST_CAL_ADD;
      end
      sca_pkg::ST_CAL_ADD: begin
        cmd.cal_add = 1'b1;
        state_nxt   = sca_pkg::ST_SQ_RD;
      end
      sca_pkg::ST_SQ_RD:  state_nxt = sca_pkg::ST_SQ_MUL;
      sca_pkg::ST_SQ_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = sca_pkg::ST_SQ_WAIT;
      end
      sca_pkg::ST_SQ_WAIT: begin
        if (sts.mul_done) state_nxt = sca_pkg::ST_SQ_ACC;
      end
      sca_pkg::ST_SQ_ACC: begin
        cmd.acc_sq = 1'b1;
        state_nxt  = sts.elem_last ? sca_pkg::ST_LIMIT : sca_pkg::ST_SQ_RD;
      end
      sca_pkg::ST_LIMIT: begin
        cmd.limit_calc = 1'b1;
        state_nxt      = sca_pkg::ST_KP_RD;
      end
      sca_pkg::ST_KP_RD:  state_nxt = sca_pkg::ST_KP_MUL;
      sca_pkg::ST_KP_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = sca_pkg::ST_KP_WAIT;
      end
      sca_pkg::ST_KP_WAIT: begin
        if (sts.mul_done) state_nxt = sca_pkg::ST_KP_ACC;
      end
      sca_pkg::ST_KP_ACC: begin
        cmd.acc_keep = 1'b1;
        state_nxt    = sts.elem_last ? sca_pkg::ST_KEEP_DIV : sca_pkg::ST_KP_RD;
      end
      sca_pkg::ST_KEEP_DIV: begin
        if (sts.kept_zero) begin
          state_nxt = sca_pkg::ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = sca_pkg::DIV_KEPT;
          state_nxt     = sca_pkg::ST_KEEP_WAIT;
        end
      end
      sca_pkg::ST_KEEP_WAIT: begin
        if (sts.div_done) state_nxt = sca_pkg::ST_OUT;
      end
      sca_pkg::ST_OUT: begin
        cmd.out_fire = 1'b1;
        state_nxt    = sca_pkg::ST_IDLE;
      end
      default: state_nxt = sca_pkg::ST_IDLE;
    endcase
  end

  // An accepted word always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // After a result the block is free again
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_fire |=> !busy)
    else $error("block still busy after result");

  // The divider is running in the cycle after its start
  a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done)
    else $error("divider reported done straight after start");

  // The multiplier is running in the cycle after its start
  a_mul_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |=> !sts.mul_done)
    else $error("multiplier reported done straight after start");

endmodule

`default_nettype wire

// ----- hw/rtl/sca_datapath.sv -----
// ----------------------------------------------------------------------------
// sca_datapath: reading store, accumulators and arithmetic units
// Converts samples to readings, keeps the batch in a small memory and owns a
// shift-add squarer, a reciprocal multiplier for the batch mean and a
// restoring divider for the kept mean.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_datapath #(
  parameter int SAMPLE_COUNT  = 10,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sca_pkg::cfg_t                cfg,
  input  wire logic [sca_pkg::RAW_W-1:0]    in_raw_sample,
  input  wire sca_pkg::dp_cmd_t             cmd,
  output sca_pkg::dp_sts_t                  sts,
  output logic                              out_valid,
  output logic signed [sca_pkg::TEMP_W-1:0] out_temperature,
  output logic                              out_status,
  output logic [sca_pkg::KEPT_W-1:0]        out_kept_count
);

  // Derived widths
  localparam int RW  = (FRACTION_BITS + 13 > 19) ? FRACTION_BITS + 13 : 19;
  localparam int AW  = $clog2(SAMPLE_COUNT);
  localparam int IW  = $clog2(SAMPLE_COUNT + 1);
  localparam int SW  = RW + $clog2(SAMPLE_COUNT);
  localparam int PRW = RW + 17;
  localparam int CW  = RW + 4;
  localparam int MW  = CW + 1;
  localparam int PW  = (2 * MW > sca_pkg::SQ_W) ? 2 * MW : sca_pkg::SQ_W + 1;
  localparam int SH  = 16 - FRACTION_BITS;
  localparam int DCW = $clog2(SW + 1);
  localparam int MCW = $clog2(MW + 1);
  localparam int KW  = sca_pkg::KEPT_W;
  // Reciprocal shift: exact truncated quotient for every sum magnitude
  localparam int RK  = SW + 2 * AW;

  localparam logic [KW-1:0]      N_K   = KW'(SAMPLE_COUNT);
  localparam logic signed [CW:0] BIAS  = (CW + 1)'((1 << FRACTION_BITS) - 1);
  localparam logic signed [CW:0] TMIN  = (CW + 1)'(sca_pkg::TEMP_MIN);
  localparam logic signed [CW:0] TMAX  = (CW + 1)'(sca_pkg::TEMP_MAX);
  localparam logic [RK-1:0]      MEAN_RECIP =
    RK'(((64'd1 << RK) + 64'(SAMPLE_COUNT - 1)) / 64'(SAMPLE_COUNT));

  // Sample capture and conversion
  logic [sca_pkg::RAW_W-1:0] raw_r;
  logic [27:0]               slope_prod_w;
  logic signed [RW-1:0]      reading_w;
  logic [IW-1:0]             samp_idx_r;
  logic signed [SW-1:0]      reading_sum_r;

  // Reading store
  logic signed [RW-1:0] store_mem [SAMPLE_COUNT];
  logic signed [RW-1:0] rd_data_r;
  logic [AW-1:0]        elem_r;

  // Mean and calibration
  logic [SW+RK-1:0]      mean_prod_w;
  logic [SW+RK-1:0]      mean_prod_r;
  logic                  mean_neg_r;
  logic [SW-1:0]         mean_q_w;
  logic signed [SW:0]    mean_sgn_w;
  logic signed [RW-1:0]  mean_r;
  logic signed [PRW-1:0] cal_prod_r;
  logic signed [CW-1:0]  cm_r;
  logic signed [CW-1:0]  cm_w;

  // Deviation squarer
  logic signed [CW:0]   dev_w;
  logic [MW-1:0]        dmag_w;
  logic [2*MW-1:0]      mcand_r;
  logic [MW-1:0]        mplier_r;
  logic [2*MW-1:0]      macc_r;
  logic [MCW-1:0]       mcnt_r;
  logic                 mbusy_r;
  logic [PW-1:0]        sq_ext_w;
  logic [sca_pkg::SQ_W-1:0] sq_w;

  // Outlier test
  logic [sca_pkg::SQ_W-1:0]    sqsum_r;
  logic [sca_pkg::SQ_W:0]      sqsum_add_w;
  logic [sca_pkg::SQ_W-1:0]    limit_r;
  logic [sca_pkg::SQ_W+KW-1:0] scaled_w;
  logic [sca_pkg::SQ_W-1:0]    scaled_sat_w;
  logic signed [SW-1:0]        kept_sum_r;
  logic [KW-1:0]               kept_cnt_r;

  // Divider
  logic signed [SW-1:0] dvd_w;
  logic [SW-1:0]        dvd_mag_w;
  logic [SW-1:0]        dq_r;
  logic [KW-1:0]        drem_r;
  logic [KW-1:0]        ddiv_r;
  logic                 dneg_r;
  logic [DCW-1:0]       dcnt_r;
  logic                 dbusy_r;
  logic [KW+1:0]        dtrial_w;
  logic signed [SW:0]   dres_w;

  // Result shaping
  logic signed [CW-1:0] res_w;
  logic signed [CW:0]   res_ext_w;
  logic signed [CW:0]   res_rnd_w;
  logic signed [CW:0]   whole_w;
  logic signed [CW:0]   sat_w;

  // Output registers
  logic                              out_valid_r;
  logic signed [sca_pkg::TEMP_W-1:0] out_temp_r;
  logic                              out_status_r;
  logic [KW-1:0]                     out_kept_r;

  // Convert the captured sample to a Q reading
  assign slope_prod_w = 28'(cfg.sensor_slope) * 28'(raw_r);
  assign reading_w    = $signed(RW'(cfg.sensor_intercept)) - $signed(RW'(slope_prod_w >> SH));

  // Batch mean by reciprocal multiplication, truncated toward zero
  assign mean_prod_w = (SW + RK)'(dvd_mag_w) * (SW + RK)'(MEAN_RECIP);
  assign mean_q_w    = SW'(mean_prod_r >> RK);
  assign mean_sgn_w  = mean_neg_r ? -$signed({1'b0, mean_q_w}) : $signed({1'b0, mean_q_w});

  // Calibrated mean and deviation of the stored reading
  assign cm_w   = CW'(cal_prod_r >>> sca_pkg::GAIN_SHIFT) + CW'(cfg.calib_offset);
  assign dev_w  = (CW + 1)'(rd_data_r) - (CW + 1)'(cm_r);
  assign dmag_w = dev_w[CW] ? MW'(-dev_w) : MW'(dev_w);

  // Saturate the square to 64 bits
  assign sq_ext_w = PW'(macc_r);
  assign sq_w     = (|sq_ext_w[PW-1:sca_pkg::SQ_W]) ? '1 : sq_ext_w[sca_pkg::SQ_W-1:0];

  assign sqsum_add_w  = {1'b0, sqsum_r} + {1'b0, sq_w};
  assign scaled_w     = (sca_pkg::SQ_W + KW)'(sq_w) * (sca_pkg::SQ_W + KW)'(N_K);
  assign scaled_sat_w = (|scaled_w[sca_pkg::SQ_W+KW-1:sca_pkg::SQ_W]) ? '1 :
                        scaled_w[sca_pkg::SQ_W-1:0];

  // Divider operands and signed quotient
  assign dvd_w     = (cmd.div_sel == sca_pkg::DIV_KEPT) ? kept_sum_r : reading_sum_r;
  assign dvd_mag_w = dvd_w[SW-1] ? SW'(-dvd_w) : SW'(dvd_w);
  assign dtrial_w  = {1'b0, drem_r, dq_r[SW-1]} - {2'b00, ddiv_r};
  assign dres_w    = dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});

  // Whole degrees, truncated toward zero and saturated
  assign res_w     = (kept_cnt_r == '0) ? cm_r : CW'(dres_w);
  assign res_ext_w = (CW + 1)'(res_w);
  assign res_rnd_w = res_w[CW-1] ? res_ext_w + BIAS : res_ext_w;
  assign whole_w   = res_rnd_w >>> FRACTION_BITS;
  assign sat_w     = (whole_w < TMIN) ? TMIN : ((whole_w > TMAX) ? TMAX : whole_w);

  // Status towards the controller
  always_comb begin
    sts.in_bad     = (raw_r < cfg.low_limit) || (raw_r > cfg.high_limit);
    sts.batch_last = (samp_idx_r == IW'(SAMPLE_COUNT - 1));
    sts.div_done   = !dbusy_r;
    sts.mul_done   = !mbusy_r;
    sts.elem_last  = (elem_r == AW'(SAMPLE_COUNT - 1));
    sts.kept_zero  = (kept_cnt_r == '0);
  end

  // Latch the accepted sample
  always_ff @(posedge clk) begin
    if (cmd.capture) raw_r <= in_raw_sample;
  end

  // Batch count and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_idx_r    <= '0;
      reading_sum_r <= '0;
    end else if (cmd.abort || cmd.out_fire) begin
      samp_idx_r    <= '0;
      reading_sum_r <= '0;
    end else if (cmd.commit) begin
      samp_idx_r    <= samp_idx_r + IW'(1);
      reading_sum_r <= reading_sum_r + SW'(reading_w);
    end
  end

  // Reading store: write on commit, registered read at the element pointer
  always_ff @(posedge clk) begin
    if (cmd.commit) store_mem[samp_idx_r[AW-1:0]] <= reading_w;
    rd_data_r <= store_mem[elem_r];
  end

  // Element pointer for the two passes
  always_ff @(posedge clk) begin
    if (cmd.cal_add) begin
      elem_r <= '0;
    end else if (cmd.acc_sq || cmd.acc_keep) begin
      elem_r <= sts.elem_last ? '0 : elem_r + AW'(1);
    end
  end

  // Mean product, mean, gain product and calibrated mean
  always_ff @(posedge clk) begin
    if (cmd.mean_mul) begin
      mean_prod_r <= mean_prod_w;
      mean_neg_r  <= dvd_w[SW-1];
    end
    if (cmd.mean_load) mean_r <= RW'(mean_sgn_w);
    if (cmd.cal_mul)   cal_prod_r <= $signed({1'b0, cfg.calib_gain}) * mean_r;
    if (cmd.cal_add)   cm_r <= cm_w;
  end

  // Shift-add squarer, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
    end else if (cmd.mul_start) begin
      mcand_r  <= (2 * MW)'(dmag_w);
      mplier_r <= dmag_w;
      macc_r   <= '0;
      mcnt_r   <= MCW'(MW);
      mbusy_r  <= 1'b1;
    end else if (mbusy_r) begin
      if (mplier_r[0]) macc_r <= macc_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      mcnt_r   <= mcnt_r - MCW'(1);
      if (mcnt_r == MCW'(1)) mbusy_r <= 1'b0;
    end
  end

  // Squared deviation sum, limit and kept accumulation
  always_ff @(posedge clk) begin
    if (cmd.cal_add) begin
      sqsum_r    <= '0;
      kept_sum_r <= '0;
      kept_cnt_r <= '0;
    end else begin
      if (cmd.acc_sq) begin
        sqsum_r <= sqsum_add_w[sca_pkg::SQ_W] ? '1 : sqsum_add_w[sca_pkg::SQ_W-1:0];
      end
      if (cmd.limit_calc) begin
        limit_r <= (|sqsum_r[sca_pkg::SQ_W-1:sca_pkg::SQ_W-2]) ? '1 :
                   {sqsum_r[sca_pkg::SQ_W-3:0], 2'b00};
      end
      if (cmd.acc_keep && (scaled_sat_w <= limit_r)) begin
        kept_sum_r <= kept_sum_r + SW'(rd_data_r);
        kept_cnt_r <= kept_cnt_r + KW'(1);
      end
    end
  end

  // Restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dneg_r  <= dvd_w[SW-1];
      dq_r    <= dvd_mag_w;
      drem_r  <= '0;
      ddiv_r  <= (cmd.div_sel == sca_pkg::DIV_KEPT) ? kept_cnt_r : N_K;
      dcnt_r  <= DCW'(SW);
      dbusy_r <= 1'b1;
    end else if (dbusy_r) begin
      if (!dtrial_w[KW+1]) begin
        drem_r <= dtrial_w[KW-1:0];
        dq_r   <= {dq_r[SW-2:0], 1'b1};
      end else begin
        drem_r <= {drem_r[KW-2:0], dq_r[SW-1]};
        dq_r   <= {dq_r[SW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - DCW'(1);
      if (dcnt_r == DCW'(1)) dbusy_r <= 1'b0;
    end
  end

  // Result word: strobe for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_fire || cmd.abort;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.abort) begin
      out_temp_r   <= '0;
      out_status_r <= sca_pkg::STATUS_ABORT;
      out_kept_r   <= '0;
    end else if (cmd.out_fire) begin
      out_temp_r   <= sat_w[sca_pkg::TEMP_W-1:0];
      out_status_r <= sca_pkg::STATUS_OK;
      out_kept_r   <= kept_cnt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = out_temp_r;
  assign out_status      = out_status_r;
  assign out_kept_count  = out_kept_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sigma_clipped_sensor_average_unit.sv -----
// ----------------------------------------------------------------------------
// sigma_clipped_sensor_average_unit: outlier-rejecting sensor average
// Averages a batch of raw sensor samples, drops two-sigma outliers and
// returns the refined temperature in whole degrees.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_raw_sample and pulse start while busy is low; the word is
//   taken at that edge. A sample that does not finish a batch keeps busy high
//   for one cycle. A sample outside the window gives an abort result
//   (status 1) on the out_ ports, by way of the sample register and the
//   registered output, and restarts the batch.
//   The SAMPLE_COUNT-th good sample starts the batch work: the mean by
//   reciprocal multiply, two passes over the store through the bit-serial
//   squarer of MW = RW + 5 bits (RW = max(19, FRACTION_BITS + 13)) and the
//   divider for the kept mean, SW = RW + clog2(SAMPLE_COUNT) bits wide
//   (skipped when nothing is kept). busy stays high through this work and
//   drops as the result appears.
//   Output: each result sits on the out_ ports for one cycle with out_valid
//   high; the receiver cannot stall, so no result is ever held back.
//   Configuration: cfg_ready is always high; write only while busy is low.
//   Reset (rst_n low, synchronous) restores the register defaults and empties
//   the current batch; the reading store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sigma_clipped_sensor_average_unit #(
  parameter int SAMPLE_COUNT  = 10,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [sca_pkg::RAW_W-1:0]        in_raw_sample,
  output logic                                  out_valid,
  output logic signed [sca_pkg::TEMP_W-1:0]     out_temperature,
  output logic                                  out_status,
  output logic [sca_pkg::KEPT_W-1:0]            out_kept_count,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sca_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sca_pkg::cfg_t    cfg;
  sca_pkg::dp_cmd_t cmd;
  sca_pkg::dp_sts_t sts;

  // Configuration registers
  sca_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer
  sca_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Arithmetic and storage
  sca_datapath #(
    .SAMPLE_COUNT  (SAMPLE_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_raw_sample   (in_raw_sample),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_temperature (out_temperature),
    .out_status      (out_status),
    .out_kept_count  (out_kept_count)
  );

endmodule

`default_nettype wire

// ----- verif/sigma_clipped_sensor_average_unit_test.sv -----
// ----------------------------------------------------------------------------
// sigma_clipped_sensor_average_unit_test: self-checking bench of the unit
// Drives raw sensor words with random gaps, tracks every accepted word in a
// behavioural model of the batch average and its two-sigma clipping, and
// checks each result word against the oldest prediction. Several register
// settings are visited, among them the extremes and an empty window.
// ----------------------------------------------------------------------------
`default_nettype none

module sigma_clipped_sensor_average_unit_test;

  localparam int BATCH       = 10;
  localparam int FRAC        = 8;
  localparam int DRAIN_WAIT  = 800;
  localparam int STALL_LIMIT = 6000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 115;

  typedef struct packed {
    logic signed [sca_pkg::TEMP_W-1:0] temp;
    logic                              status;
    logic [sca_pkg::KEPT_W-1:0]        kept;
  } result_t;

  typedef struct packed {
    logic [sca_pkg::RAW_W-1:0] raw;
    logic                      typed;
    result_t                   res;
  } row_t;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [sca_pkg::RAW_W-1:0]         in_raw_sample;
  logic                              out_valid;
  logic signed [sca_pkg::TEMP_W-1:0] out_temperature;
  logic                              out_status;
  logic [sca_pkg::KEPT_W-1:0]        out_kept_count;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [sca_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [sca_pkg::CFG_DATA_W-1:0]    cfg_data;

  sigma_clipped_sensor_average_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_raw_sample(in_raw_sample), .out_valid(out_valid),
    .out_temperature(out_temperature), .out_status(out_status),
    .out_kept_count(out_kept_count), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model copy of the registers
  longint lo_lim, hi_lim, intercept, slope, gain, offset;
  // Model copy of the batch
  longint readings [BATCH];
  int     fill;
  longint batch_sum;

  result_t pending_results [$];
  int      mismatches;
  int      idle_cycles;
  logic    override_on;
  result_t override_res;
  int      quiet_phase;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Whole degrees, truncated toward zero and saturated
  function automatic logic signed [sca_pkg::TEMP_W-1:0] to_degrees(longint q);
    longint whole;
    whole = q / (64'sd1 <<< FRAC);
    if (whole < sca_pkg::TEMP_MIN) whole = sca_pkg::TEMP_MIN;
    if (whole > sca_pkg::TEMP_MAX) whole = sca_pkg::TEMP_MAX;
    return whole[sca_pkg::TEMP_W-1:0];
  endfunction

  // Advance the batch model by one word; returns 1 when a result is due
  function automatic bit refine_sample(logic [sca_pkg::RAW_W-1:0] raw,
                                       output result_t res);
    longint reading, mean, cal, d, sq_sum, kept_sum;
    int     kept;
    res = '0;
    if (raw < lo_lim || raw > hi_lim) begin
      fill      = 0;
      batch_sum = 0;
      res.status = sca_pkg::STATUS_ABORT;
      return 1'b1;
    end
    reading = intercept - ((slope * longint'(raw)) >> (16 - FRAC));
    if (fill >= BATCH) fill = 0;
    readings[fill] = reading;
    batch_sum += reading;
    fill++;
    if (fill < BATCH) return 1'b0;
    mean = batch_sum / BATCH;
    cal  = ((gain * mean) >>> sca_pkg::GAIN_SHIFT) + offset;
    sq_sum = 0;
    for (int i = 0; i < BATCH; i++) begin
      d = readings[i] - cal;
      sq_sum += d * d;
    end
    kept_sum = 0;
    kept     = 0;
    for (int i = 0; i < BATCH; i++) begin
      d = readings[i] - cal;
      if (d * d * BATCH <= 4 * sq_sum) begin
        kept_sum += readings[i];
        kept++;
      end
    end
    res.temp   = to_degrees(kept > 0 ? kept_sum / kept : cal);
    res.status = sca_pkg::STATUS_OK;
    res.kept   = kept[sca_pkg::KEPT_W-1:0];
    fill      = 0;
    batch_sum = 0;
    return 1'b1;
  endfunction

  function automatic void apply_register(logic [sca_pkg::CFG_IDX_W-1:0] idx,
                                         logic [sca_pkg::CFG_DATA_W-1:0] data);
    case (sca_pkg::cfg_idx_t'(idx))
      sca_pkg::CFG_LOW_LIMIT:        lo_lim    = data[11:0];
      sca_pkg::CFG_HIGH_LIMIT:       hi_lim    = data[11:0];
      sca_pkg::CFG_SENSOR_INTERCEPT: intercept = data[17:0];
      sca_pkg::CFG_SENSOR_SLOPE:     slope     = data[15:0];
      sca_pkg::CFG_CALIB_GAIN:       gain      = data[15:0];
      sca_pkg::CFG_CALIB_OFFSET:     offset    = longint'($signed(data[15:0]));
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  // Check result words, predict accepted words, track register writes
  always @(posedge clk) begin
    result_t want;
    result_t pred;
    bit      seen;
    seen = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        seen = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word, status", out_status, -1);
        end else begin
          want = pending_results.pop_front();
          if (out_temperature !== want.temp)
            report_mismatch("temperature", out_temperature, want.temp);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_kept_count !== want.kept)
            report_mismatch("kept_count", out_kept_count, want.kept);
        end
      end
      if (start && !busy) begin
        seen = 1'b1;
        if (refine_sample(in_raw_sample, pred))
          pending_results.push_back(override_on ? override_res : pred);
      end
      if (cfg_valid && cfg_ready) begin
        seen = 1'b1;
        apply_register(cfg_index, cfg_data);
      end
      idle_cycles <= seen ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet_phase != 0) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // Send one word; start stays high into a back-to-back word
  task automatic send_word(logic [sca_pkg::RAW_W-1:0] raw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_raw_sample <= raw;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every result word is in and the unit is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_register(sca_pkg::cfg_idx_t idx,
                                logic [sca_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(logic [11:0] lo, logic [11:0] hi);
    write_register(sca_pkg::CFG_LOW_LIMIT, {6'd0, lo});
    write_register(sca_pkg::CFG_HIGH_LIMIT, {6'd0, hi});
  endtask

  localparam result_t ABORT_RES = '{temp: '0, status: sca_pkg::STATUS_ABORT, kept: '0};
  localparam result_t NO_RES    = '0;

  row_t directed [17];

  initial begin
    logic [sca_pkg::RAW_W-1:0] raw;
    int lo_pick, hi_pick;

    // Out-of-window words, a cut batch, then a batch with both edges in it
    directed = '{
      '{raw: 12'd0,    typed: 1'b1, res: ABORT_RES},
      '{raw: 12'd99,   typed: 1'b1, res: ABORT_RES},
      '{raw: 12'd4001, typed: 1'b1, res: ABORT_RES},
      '{raw: 12'd4095, typed: 1'b1, res: ABORT_RES},
      '{raw: 12'd100,  typed: 1'b0, res: NO_RES},
      '{raw: 12'd4000, typed: 1'b0, res: NO_RES},
      '{raw: 12'd0,    typed: 1'b1, res: ABORT_RES},
      '{raw: 12'd100,  typed: 1'b0, res: NO_RES},
      '{raw: 12'd4000, typed: 1'b0, res: NO_RES},
      '{raw: 12'd2048, typed: 1'b0, res: NO_RES},
      '{raw: 12'd2048, typed: 1'b0, res: NO_RES},
      '{raw: 12'd2047, typed: 1'b0, res: NO_RES},
      '{raw: 12'd2048, typed: 1'b0, res: NO_RES},
      '{raw: 12'd1365, typed: 1'b0, res: NO_RES},
      '{raw: 12'd2730, typed: 1'b0, res: NO_RES},
      '{raw: 12'd2048, typed: 1'b0, res: NO_RES},
      '{raw: 12'd2048, typed: 1'b0, res: NO_RES}
    };

    rst_n = 1'b0;
    start = 1'b0;
    in_raw_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    mismatches  = 0;
    idle_cycles = 0;
    override_on = 1'b0;
    override_res = '0;
    quiet_phase = 0;
    lo_lim = sca_pkg::LOW_LIMIT_RST;  hi_lim = sca_pkg::HIGH_LIMIT_RST;
    intercept = sca_pkg::INTERCEPT_RST; slope = sca_pkg::SLOPE_RST;
    gain = sca_pkg::GAIN_RST; offset = sca_pkg::OFFSET_RST;
    fill = 0;
    batch_sum = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset settings
    foreach (directed[i]) begin
      override_on  = directed[i].typed;
      override_res = directed[i].res;
      send_word(directed[i].raw);
    end
    drain();
    override_on = 1'b0;

    // Random phases, each after the first under a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1: set_window(12'd0, 12'd4095);
          2: set_window(12'd3000, 12'd1000);
          3: set_window(12'd4095, 12'd4095);
          4: set_window(12'd0, 12'd0);
          default: begin
            lo_pick = $urandom_range(4095);
            hi_pick = $urandom_range(4095, lo_pick);
            set_window(lo_pick[11:0], hi_pick[11:0]);
          end
        endcase
        case (p)
          1: begin
            write_register(sca_pkg::CFG_SENSOR_INTERCEPT, 18'h3FFFF);
            write_register(sca_pkg::CFG_SENSOR_SLOPE, 18'h0FFFF);
            write_register(sca_pkg::CFG_CALIB_GAIN, 18'h0FFFF);
            write_register(sca_pkg::CFG_CALIB_OFFSET, 18'h08000);
          end
          3: begin
            write_register(sca_pkg::CFG_SENSOR_INTERCEPT, 18'h00000);
            write_register(sca_pkg::CFG_SENSOR_SLOPE, 18'h00000);
            write_register(sca_pkg::CFG_CALIB_GAIN, 18'h00000);
            write_register(sca_pkg::CFG_CALIB_OFFSET, 18'h07FFF);
          end
          default: begin
            write_register(sca_pkg::CFG_SENSOR_INTERCEPT, 18'($urandom_range(262143)));
            write_register(sca_pkg::CFG_SENSOR_SLOPE, 18'($urandom_range(262143)));
            write_register(sca_pkg::CFG_CALIB_GAIN, 18'($urandom_range(262143)));
            write_register(sca_pkg::CFG_CALIB_OFFSET, 18'($urandom_range(262143)));
          end
        endcase
      end
      quiet_phase = (p % 4 == 3) ? 1 : 0;

      // Mostly in-window words so batches complete, a few strays anywhere
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (lo_lim <= hi_lim && $urandom_range(99) < 94)
          raw = 12'($urandom_range(int'(hi_lim), int'(lo_lim)));
        else
          raw = 12'($urandom_range(4095));
        send_word(raw);
      end
      drain();
    end

    if (pending_results.size() != 0)
      report_mismatch("words never seen", 0, pending_results.size());
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
